FILE: rtl/bcgc_pkg.sv
package bcgc_pkg;

   localparam int unsigned STAMP_WIDTH     = 32;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_WINDOW = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS    = 1'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] DOUBLE_WINDOW_RESET = 16'd270;
   localparam logic [CSR_DATA_WIDTH-1:0] LONG_PRESS_RESET    = 16'd500;

   typedef struct packed {
      logic                   button_level;
      logic [STAMP_WIDTH-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic emit_next;
      logic emit_prev;
      logic emit_esc;
      logic any_activity;
   } rsp_type;

endpackage

FILE: rtl/bcgc_classify.sv
module bcgc_classify (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  bcgc_pkg::req_type                     item,
   input  logic [bcgc_pkg::CSR_DATA_WIDTH-1:0]   double_window,
   input  logic [bcgc_pkg::CSR_DATA_WIDTH-1:0]   long_press,
   output bcgc_pkg::rsp_type                     result
);

   logic                                last_level_ff, last_level_in;
   logic [bcgc_pkg::STAMP_WIDTH-1:0]    press_start_ff, press_start_in;
   logic [bcgc_pkg::STAMP_WIDTH-1:0]    first_release_ff, first_release_in;
   logic                                awaiting_ff, awaiting_in;
   logic                                long_fired_ff, long_fired_in;

   logic                                level;
   logic                                press_edge;
   logic                                release_edge;
   logic [bcgc_pkg::STAMP_WIDTH-1:0]    held_ms;
   logic [bcgc_pkg::STAMP_WIDTH-1:0]    since_release_ms;
   logic                                long_hit;
   logic                                lf_after_press;
   logic                                aw_after_long;
   logic                                in_window;
   logic                                start_window;
   logic                                e_prev;
   logic                                e_next;

   always_comb begin
      level            = item.button_level;
      press_edge       = level && !last_level_ff;
      release_edge     = !level && last_level_ff;
      // on a press edge the hold starts now, so the held time is zero
      held_ms          = press_edge ? '0 : (item.now_ms - press_start_ff);
      since_release_ms = item.now_ms - first_release_ff;
      lf_after_press   = press_edge ? 1'b0 : long_fired_ff;
      long_hit         = level && !lf_after_press &&
                         (held_ms >= {{(bcgc_pkg::STAMP_WIDTH-bcgc_pkg::CSR_DATA_WIDTH){1'b0}},
                                      long_press});
      aw_after_long    = long_hit ? 1'b0 : awaiting_ff;
      in_window        = since_release_ms <=
                         {{(bcgc_pkg::STAMP_WIDTH-bcgc_pkg::CSR_DATA_WIDTH){1'b0}},
                          double_window};

      e_prev       = release_edge && !lf_after_press && aw_after_long && in_window;
      start_window = release_edge && !lf_after_press && !(aw_after_long && in_window);
      // a freshly opened window has zero elapsed time and cannot expire here
      e_next       = aw_after_long && !level && !release_edge && !in_window;

      last_level_in    = level;
      press_start_in   = press_edge ? item.now_ms : press_start_ff;
      first_release_in = start_window ? item.now_ms : first_release_ff;
      long_fired_in    = release_edge ? 1'b0 : (lf_after_press || long_hit);
      awaiting_in      = start_window || (aw_after_long && !e_prev && !e_next);

      result.emit_next    = e_next;
      result.emit_prev    = e_prev;
      result.emit_esc     = long_hit;
      result.any_activity = level || awaiting_in || e_next || e_prev || long_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff    <= 1'b0;
         press_start_ff   <= '0;
         first_release_ff <= '0;
         awaiting_ff      <= 1'b0;
         long_fired_ff    <= 1'b0;
      end else if (fire) begin
         last_level_ff    <= last_level_in;
         press_start_ff   <= press_start_in;
         first_release_ff <= first_release_in;
         awaiting_ff      <= awaiting_in;
         long_fired_ff    <= long_fired_in;
      end
   end

endmodule

FILE: rtl/button_click_gesture_classifier.sv
// Button gesture classifier: one poll item in, one gesture item out.
// req channel: valid/ready, req_data carries the debounced button level and
//   a free-running millisecond stamp. Edges are found against the previous
//   poll; elapsed times wrap modulo 2^32.
// rsp channel: valid/ready, rsp_data flags next (single click expired),
//   prev (double click), esc (long press, once per hold) and any activity.
// csr channel: valid/ready, always ready. Index 0 is the double-click
//   window, index 1 the long-press time, both in ms. Write only while idle.
// Path: an accepted item passes the input register, then the result
//   register, and rsp_valid rises once it lands there. Throughput: one
//   item per cycle while rsp_ready stays high.
// Reset: synchronous; clears the pipeline and gesture state and loads the
//   window and long-press defaults (270 ms, 500 ms).
// Stall: when rsp_ready is low the result holds; the input register still
//   takes one item, then req_ready drops until the result drains.
module button_click_gesture_classifier (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  bcgc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output bcgc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bcgc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bcgc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   logic [bcgc_pkg::CSR_DATA_WIDTH-1:0] double_window_ff;
   logic [bcgc_pkg::CSR_DATA_WIDTH-1:0] long_press_ff;

   logic              in_valid_ff;
   bcgc_pkg::req_type in_data_ff;
   logic              rsp_valid_ff;
   bcgc_pkg::rsp_type rsp_data_ff;
   bcgc_pkg::rsp_type result;
   logic              advance;
   logic              req_fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         double_window_ff <= bcgc_pkg::DOUBLE_WINDOW_RESET;
         long_press_ff    <= bcgc_pkg::LONG_PRESS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            bcgc_pkg::CSR_DOUBLE_WINDOW: double_window_ff <= csr_wdata;
            bcgc_pkg::CSR_LONG_PRESS:    long_press_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   bcgc_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .item          (in_data_ff),
      .double_window (double_window_ff),
      .long_press    (long_press_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_gesture: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({rsp_data_ff.emit_next, rsp_data_ff.emit_prev,
                                   rsp_data_ff.emit_esc}) <= 1)
      else $error("more than one gesture in one item");

   a_gesture_is_activity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.emit_next || rsp_data_ff.emit_prev ||
                        rsp_data_ff.emit_esc)) |-> rsp_data_ff.any_activity)
      else $error("gesture without activity flag");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("classified item lost before result register");

   a_esc_needs_press: assert property (@(posedge clock) disable iff (reset)
      (advance && result.emit_esc) |-> in_data_ff.button_level)
      else $error("escape with button released");
`endif

endmodule

FILE: dv/tb_button_click_gesture_classifier.sv
`timescale 1ns / 100ps

module tb_button_click_gesture_classifier;
   import bcgc_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 600000;
   localparam int unsigned DIRECTED_POLLS = 25;
   localparam int unsigned PHASE_POLLS   = 185;
   localparam int unsigned PHASE_COUNT   = 10;
   localparam int unsigned SETTLE_CYCLES = 4;

   // Tracks button gesture state and holds the gestures still owed by the block.
   class gesture_scoreboard;
      logic [15:0] window_ms;
      logic [15:0] long_ms;
      logic        level_q;
      logic [31:0] press_stamp;
      logic [31:0] release_stamp;
      logic        awaiting_second;
      logic        esc_fired;
      rsp_type     expected_gestures[$];
      int unsigned errors;

      function new();
         window_ms       = DOUBLE_WINDOW_RESET;
         long_ms         = LONG_PRESS_RESET;
         level_q         = 1'b0;
         press_stamp     = '0;
         release_stamp   = '0;
         awaiting_second = 1'b0;
         esc_fired       = 1'b0;
         errors          = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] value);
         if (idx == CSR_DOUBLE_WINDOW) begin
            window_ms = value;
         end else if (idx == CSR_LONG_PRESS) begin
            long_ms = value;
         end
      endfunction

      function int unsigned pending();
         return expected_gestures.size();
      endfunction

      function void note_poll(req_type item);
         rsp_type     want;
         logic        down;
         logic        press_seen;
         logic        release_seen;
         logic [31:0] held;
         logic [31:0] since;
         down         = item.button_level;
         press_seen   = down && !level_q;
         release_seen = !down && level_q;
         want         = '0;
         if (press_seen) begin
            esc_fired   = 1'b0;
            press_stamp = item.now_ms;
         end
         held = item.now_ms - press_stamp;
         if (down && !esc_fired && held >= {16'd0, long_ms}) begin
            esc_fired       = 1'b1;
            awaiting_second = 1'b0;
            want.emit_esc   = 1'b1;
         end
         if (release_seen) begin
            since = item.now_ms - release_stamp;
            if (esc_fired) begin
               // release that ends a long hold is not a click
               esc_fired = 1'b0;
            end else if (awaiting_second && since <= {16'd0, window_ms}) begin
               awaiting_second = 1'b0;
               want.emit_prev  = 1'b1;
            end else begin
               awaiting_second = 1'b1;
               release_stamp   = item.now_ms;
            end
         end
         since = item.now_ms - release_stamp;
         if (awaiting_second && !down && since > {16'd0, window_ms}) begin
            awaiting_second = 1'b0;
            want.emit_next  = 1'b1;
         end
         want.any_activity = down || awaiting_second || want.emit_next || want.emit_prev
                             || want.emit_esc;
         level_q = down;
         expected_gestures.push_back(want);
      endfunction

      function void check_field(string name, logic want, logic got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_gesture(rsp_type got);
         rsp_type want;
         if (expected_gestures.size() == 0) begin
            $display("%0t: gesture item with none expected, expected none actual %b", $time, got);
            errors++;
            return;
         end
         want = expected_gestures.pop_front();
         check_field("emit_next", want.emit_next, got.emit_next);
         check_field("emit_prev", want.emit_prev, got.emit_prev);
         check_field("emit_esc", want.emit_esc, got.emit_esc);
         check_field("any_activity", want.any_activity, got.any_activity);
      endfunction
   endclass

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   gesture_scoreboard sb = new();

   int unsigned req_gap_max   = 19;
   int unsigned rsp_stall_max = 19;
   int unsigned polls_sent    = 0;
   int unsigned cycles        = 0;
   int unsigned cur_win       = 270;
   int unsigned cur_long      = 500;
   logic [31:0] ms_now        = '0;

   button_click_gesture_classifier u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // results are checked before the poll of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_gesture(rsp_data);
         end
         if (req_valid && req_ready) begin
            sb.note_poll(req_data);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d gestures outstanding", $time, sb.pending());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: random stall before each item
   initial begin
      int unsigned stall;
      @(posedge clock);
      forever begin
         stall = $urandom_range(rsp_stall_max, 0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_poll(input logic level, input logic [31:0] stamp);
      req_type     item;
      int unsigned gap;
      item.button_level = level;
      item.now_ms       = stamp;
      gap = $urandom_range(req_gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      polls_sent++;
   endtask

   task automatic step_ms(input logic level, input int unsigned delta);
      ms_now = ms_now + delta;
      send_poll(level, ms_now);
   endtask

   // stop sending and wait until every gesture has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, value);
      if (idx == CSR_DOUBLE_WINDOW) begin
         cur_win = 32'(value);
      end else begin
         cur_long = 32'(value);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // durations clustered on a threshold, with some spread below and beyond it
   function automatic int unsigned around_limit(int unsigned thr);
      case ($urandom_range(5, 0))
         0: return 0;
         1: return (thr == 0) ? 0 : thr - 1;
         2: return thr;
         3: return thr + 1;
         4: return $urandom_range(thr, 0);
         default: return $urandom_range(2 * thr + 2, thr);
      endcase
   endfunction

   task automatic make_gesture();
      int unsigned kind;
      int unsigned target;
      int unsigned split;
      int unsigned n;
      int unsigned delta;
      kind = $urandom_range(9, 0);
      if (kind <= 2) begin
         // single click, then idle polls around the window edge
         step_ms(1'b1, around_limit(cur_win));
         n = $urandom_range(2, 0);
         repeat (n) step_ms(1'b1, $urandom_range(cur_long / 3, 0));
         step_ms(1'b0, $urandom_range(cur_long / 3, 0));
         n = $urandom_range(3, 1);
         repeat (n) step_ms(1'b0, around_limit(cur_win));
      end else if (kind <= 5) begin
         // double click: release-to-release time lands near the window
         step_ms(1'b1, around_limit(cur_win));
         step_ms(1'b0, $urandom_range(cur_long / 3, 0));
         target = around_limit(cur_win);
         split  = $urandom_range(target, 0);
         step_ms(1'b1, split);
         step_ms(1'b0, target - split);
      end else if (kind <= 7) begin
         step_ms(1'b1, around_limit(cur_win));
         n = $urandom_range(3, 1);
         repeat (n) step_ms(1'b1, around_limit(cur_long));
         step_ms(1'b0, around_limit(cur_win));
      end else if (kind == 8) begin
         // noise, including backward jumps of the stamp
         n = $urandom_range(6, 1);
         repeat (n) begin
            case ($urandom_range(2, 0))
               0: delta = 0;
               1: delta = $urandom_range(cur_long + cur_win + 2, 0);
               default: delta = $urandom;
            endcase
            step_ms(1'($urandom_range(1, 0)), delta);
         end
      end else begin
         step_ms(1'b0, around_limit(cur_win));
      end
   endtask

   initial begin
      logic [15:0] win_cfg;
      logic [15:0] long_cfg;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // held at reset, long press exactly at the limit, release after long press
      send_poll(1'b1, 32'd0);
      send_poll(1'b1, 32'd500);
      send_poll(1'b0, 32'd600);
      // double click with the second release right on the window
      send_poll(1'b1, 32'd700);
      send_poll(1'b0, 32'd750);
      send_poll(1'b1, 32'd900);
      send_poll(1'b0, 32'd1020);
      // single click: window edge, then one past it
      send_poll(1'b1, 32'd1100);
      send_poll(1'b0, 32'd1150);
      send_poll(1'b0, 32'd1420);
      send_poll(1'b0, 32'd1421);
      // click across the stamp wrap
      send_poll(1'b1, 32'hFFFF_FF00);
      send_poll(1'b0, 32'h0000_0010);
      send_poll(1'b0, 32'h0000_0120);
      // backward jump reads as a very long hold
      send_poll(1'b1, 32'h0000_1000);
      send_poll(1'b1, 32'h0000_0FFF);
      send_poll(1'b0, 32'hFFFF_FFFF);
      send_poll(1'b0, 32'h0000_0000);

      drain();
      write_reg(CSR_DOUBLE_WINDOW, 16'd0);
      write_reg(CSR_LONG_PRESS, 16'hFFFF);
      // zero window: second release at the same stamp
      send_poll(1'b1, 32'd10);
      send_poll(1'b0, 32'd11);
      send_poll(1'b1, 32'd11);
      send_poll(1'b0, 32'd11);
      send_poll(1'b1, 32'd12);

      drain();
      write_reg(CSR_LONG_PRESS, 16'd0);
      // zero long-press time fires on the press itself
      send_poll(1'b1, 32'd30);
      send_poll(1'b0, 32'd31);
      ms_now = 32'd31;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         case (p)
            0: begin win_cfg = DOUBLE_WINDOW_RESET; long_cfg = LONG_PRESS_RESET; end
            1: begin win_cfg = 16'd0;     long_cfg = 16'd0;     end
            2: begin win_cfg = 16'hFFFF;  long_cfg = 16'hFFFF;  end
            3: begin win_cfg = 16'd0;     long_cfg = 16'hFFFF;  end
            4: begin win_cfg = 16'hFFFF;  long_cfg = 16'd0;     end
            5, 6: begin
               win_cfg  = 16'($urandom_range(600, 1));
               long_cfg = 16'($urandom_range(900, 1));
            end
            default: begin
               win_cfg  = 16'($urandom_range(16'hFFFF, 0));
               long_cfg = 16'($urandom_range(16'hFFFF, 0));
            end
         endcase
         write_reg(CSR_DOUBLE_WINDOW, win_cfg);
         write_reg(CSR_LONG_PRESS, long_cfg);
         req_gap_max   = (p % 3 == 0) ? 0 : 19;
         rsp_stall_max = (p % 4 == 1) ? 0 : 19;
         while (polls_sent < DIRECTED_POLLS + (p + 1) * PHASE_POLLS) make_gesture();
      end

      drain();
      if (sb.pending() != 0) begin
         $display("%0t: %0d gestures never arrived", $time, sb.pending());
      end
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
